// ----- src/sedd_pkg.sv -----
// ----------------------------------------------------------------------------
// sedd_pkg
// Shared types, constants and helpers of the scaled error-diffusion dither.
// ----------------------------------------------------------------------------
package sedd_pkg;

  localparam int MAX_LINE  = 1024;
  localparam int ADDR_W    = $clog2(MAX_LINE);
  localparam int OUT_W     = $clog2(MAX_LINE + 1);
  localparam int DIM_W     = 16;
  localparam int ERR_W     = 13;
  localparam int MAC_A_W   = 18;
  localparam int MAC_B_W   = 11;
  localparam int MAC_W     = MAC_A_W + MAC_B_W;
  localparam int DIV_N     = DIM_W + OUT_W;
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);

  typedef enum logic [1:0] {
    REG_MAX_WIDTH,
    REG_THRESHOLD,
    REG_SOURCE_WIDTH,
    REG_SOURCE_HEIGHT
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_CLR, ST_MUL, ST_OH_GO, ST_OH_WT, ST_W_GO, ST_W_WT, ST_H_GO, ST_H_WT,
    ST_IDLE, ST_MR, ST_MG, ST_MB, ST_L1, ST_L2, ST_L3, ST_Q1, ST_Q2, ST_Q3,
    ST_FIN, ST_EXT
  } state_e;

  typedef struct packed {
    logic                    we;
    logic [ADDR_W-1:0]       addr;
    logic signed [ERR_W-1:0] data;
  } err_wr_t;

  typedef struct packed {
    err_wr_t           wr0;
    err_wr_t           wr1;
    logic [ADDR_W-1:0] raddr;
    logic              rbank;
  } err_mem_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quot;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

  // floor(x / 255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [17:0] s;
    s = {1'b0, x} + {9'b0, x[16:8]} + 18'd1;
    return s[15:8];
  endfunction

endpackage

// ----- src/sedd_if.sv -----
// ----------------------------------------------------------------------------
// sedd channel interfaces
// Pixel input channel and dot output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sedd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface sedd_dot_if;
  logic valid;
  logic ready;
  logic ink;
  logic row_end;
  logic image_end;

  modport source (output valid, ink, row_end, image_end, input ready);
  modport sink   (input valid, ink, row_end, image_end, output ready);
endinterface

// ----- src/sedd_div.sv -----
// ----------------------------------------------------------------------------
// sedd_div
// Restoring divider, one quotient bit per cycle, used for geometry setup.
// ----------------------------------------------------------------------------
module sedd_div import sedd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_N-1:0]     dq_q;
  logic [DIM_W-1:0]     rem_q;
  logic [DIM_W-1:0]     dvs_q;
  logic [DIM_W:0]       trial;
  logic [DIM_W:0]       diff;
  logic                 ge;

  assign trial = {rem_q, dq_q[DIV_N-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_N-2:0], ge};
      rem_q <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- src/sedd_err_mem.sv -----
// ----------------------------------------------------------------------------
// sedd_err_mem
// Two banks of diffused error, one per image row, swapped at each row end.
// ----------------------------------------------------------------------------
module sedd_err_mem import sedd_pkg::*; (
  input  logic                    clk_i,
  input  err_mem_req_t            req_i,
  output logic signed [ERR_W-1:0] rdata_o
);

  logic signed [ERR_W-1:0] bank0_q [MAX_LINE];
  logic signed [ERR_W-1:0] bank1_q [MAX_LINE];
  logic signed [ERR_W-1:0] rd0_q;
  logic signed [ERR_W-1:0] rd1_q;
  logic                    sel_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr0.we) begin
      bank0_q[req_i.wr0.addr] <= req_i.wr0.data;
    end
    if (req_i.wr1.we) begin
      bank1_q[req_i.wr1.addr] <= req_i.wr1.data;
    end
    rd0_q <= bank0_q[req_i.raddr];
    rd1_q <= bank1_q[req_i.raddr];
    sel_q <= req_i.rbank;
  end

  assign rdata_o = sel_q ? rd1_q : rd0_q;

endmodule

// ----- src/scaled_error_diffusion_dither_core.sv -----
// ----------------------------------------------------------------------------
// scaled_error_diffusion_dither_core
// Nearest-neighbour downscaler and Floyd-Steinberg dither, one dot per kept
// source pixel.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i takes RGBA source pixels in raster order; dot_o gives one beat per
//   kept pixel (ink, row_end, image_end). Configuration is written through
//   cfg_we_i/cfg_idx_i/cfg_data_i while no pixel is in flight.
//   A dropped pixel is taken without leaving the idle state. A kept pixel
//   passes through the states MR, MG, MB, L1, L2, L3, Q1, Q2, Q3 and FIN,
//   and its dot beat is registered as FIN completes; at a row end the state
//   EXT then stores the last error of the next row. Compositing, luminance
//   and divide-by-1000 steps run one after another on a single
//   multiply-accumulate unit. pix_i is not ready meanwhile.
//   After reset and after each write to the width limit, source width or
//   source height, a setup pass runs: it zeroes both error rows, does one
//   multiply, then three divisions for the scale steps. pix_i is not ready
//   during setup. A stalled dot_o holds the finished beat and the next kept
//   pixel waits in its last step until the beat is taken.
// ----------------------------------------------------------------------------
module scaled_error_diffusion_dither_core import sedd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  sedd_pix_if.sink          pix_i,
  sedd_dot_if.source        dot_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [DIM_W-1:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [OUT_W-1:0]  max_w_q;
  logic [7:0]        thr_q;
  logic [DIM_W-1:0]  srcw_q, srch_q;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [OUT_W-1:0]  mw_eff, ow;

  logic [ADDR_W-1:0] clr_cnt_q;
  logic [DIM_W-1:0]  oh_q, qw_q, qh_q, rh_q;
  logic [OUT_W-1:0]  rw_q;

  logic [DIM_W-1:0]  src_col_q, src_row_q, wc_q, wr_q, out_row_q, rem_row_q;
  logic [OUT_W-1:0]  out_col_q, rem_col_q;

  logic [7:0]        pr_q, pg_q, pb_q, pa_q, cr_q, cg_q;
  logic [7:0]        cb_q;
  logic [MAC_A_W-1:0] lumx_q;
  logic [8:0]        q0_q;
  logic signed [ERR_W-1:0] terr_q, carry_q, pend1_q, pend2_q, ext_q;
  logic              dark_q, bank_q, ext_last_q;
  logic signed [8:0] e_q;

  logic [MAC_W-1:0]   mac_q;
  logic               mac_en, mac_clr;
  logic [MAC_A_W-1:0] mac_a;
  logic [MAC_B_W-1:0] mac_b;

  logic dot_valid_q, ink_q, rend_q, iend_q;

  logic         accept, keep, geo_wr, fin_go, rend, last_row, adv;
  logic         src_col_last, src_row_last;
  logic [7:0]   chan;

  logic signed [ERR_W:0]   s_sum, s_mag, s_div;
  logic [8:0]              lumv;
  logic signed [ERR_W:0]   v_raw;
  logic [7:0]              vc;
  logic                    dark_c;
  logic signed [8:0]       e_c;
  logic signed [ERR_W-1:0] e13, nxt_data, pend1_n;

  logic [OUT_W:0]   col_sum;
  logic             col_wrap;
  logic [DIM_W:0]   row_sum;
  logic             row_wrap;

  err_mem_req_t            mem_req;
  logic signed [ERR_W-1:0] mem_rdata;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  sedd_err_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  sedd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // geometry
  assign w_eff  = (srcw_q == '0) ? DIM_W'(1) : srcw_q;
  assign h_eff  = (srch_q == '0) ? DIM_W'(1) : srch_q;
  assign mw_eff = (max_w_q == '0) ? OUT_W'(1) :
                  (max_w_q > OUT_W'(MAX_LINE)) ? OUT_W'(MAX_LINE) : max_w_q;
  assign ow     = (w_eff > DIM_W'(mw_eff)) ? mw_eff : w_eff[OUT_W-1:0];

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign keep        = (out_row_q < oh_q) && (src_row_q == wr_q) && (src_col_q == wc_q);
  assign geo_wr      = cfg_we_i && (cfg_idx_i != REG_THRESHOLD);
  assign fin_go      = (state_q == ST_FIN) && (!dot_valid_q || dot_o.ready);
  assign rend        = (out_col_q == ow - 1'b1);
  assign last_row    = ({1'b0, out_row_q} + 1'b1) >= {1'b0, oh_q};
  assign adv         = (accept && !keep) || fin_go;

  assign src_col_last = ({1'b0, src_col_q} + 1'b1) >= {1'b0, w_eff};
  assign src_row_last = ({1'b0, src_row_q} + 1'b1) >= {1'b0, h_eff};

  assign chan = div255(17'd65025 - mac_q[16:0]);

  // dither arithmetic
  always_comb begin
    s_sum  = (ERR_W+1)'(terr_q) + (ERR_W+1)'(carry_q);
    s_mag  = (s_sum < 0) ? -s_sum : s_sum;
    s_div  = (s_sum < 0) ? -(s_mag >>> 4) : (s_mag >>> 4);
    lumv   = (mac_q[MAC_A_W-1:0] > lumx_q) ? q0_q - 1'b1 : q0_q;
    v_raw  = $signed({5'b0, lumv}) + s_div;
    if (v_raw < 0) begin
      vc = 8'd0;
    end else if (v_raw > 255) begin
      vc = 8'd255;
    end else begin
      vc = v_raw[7:0];
    end
    dark_c   = vc < thr_q;
    e_c      = dark_c ? $signed({1'b0, vc}) : $signed({1'b0, vc}) - 9'sd255;
    e13      = ERR_W'(e_q);
    nxt_data = pend1_q + 13'sd3 * e13;
    pend1_n  = pend2_q + 13'sd5 * e13;
  end

  assign col_sum  = {1'b0, rem_col_q} + {1'b0, rw_q};
  assign col_wrap = col_sum >= {1'b0, ow};
  assign row_sum  = {1'b0, rem_row_q} + {1'b0, rh_q};
  assign row_wrap = row_sum >= {1'b0, oh_q};

  // multiply-accumulate operand selection
  always_comb begin
    mac_en  = 1'b1;
    mac_clr = 1'b1;
    mac_a   = '0;
    mac_b   = '0;
    case (state_q)
      ST_MUL: begin
        mac_a = MAC_A_W'(h_eff);
        mac_b = MAC_B_W'(ow);
      end
      ST_MR: begin
        mac_a = MAC_A_W'(pa_q);
        mac_b = MAC_B_W'(8'd255 - pr_q);
      end
      ST_MG: begin
        mac_a = MAC_A_W'(pa_q);
        mac_b = MAC_B_W'(8'd255 - pg_q);
      end
      ST_MB: begin
        mac_a = MAC_A_W'(pa_q);
        mac_b = MAC_B_W'(8'd255 - pb_q);
      end
      ST_L1: begin
        mac_a = MAC_A_W'(cr_q);
        mac_b = MAC_B_W'(299);
      end
      ST_L2: begin
        mac_clr = 1'b0;
        mac_a   = MAC_A_W'(cg_q);
        mac_b   = MAC_B_W'(587);
      end
      ST_L3: begin
        mac_clr = 1'b0;
        mac_a   = MAC_A_W'(cb_q);
        mac_b   = MAC_B_W'(114);
      end
      ST_Q1: begin
        mac_a = mac_q[MAC_A_W-1:0];
        mac_b = MAC_B_W'(1049);
      end
      ST_Q2: begin
        mac_a = MAC_A_W'(mac_q[MAC_W-1:20]);
        mac_b = MAC_B_W'(1000);
      end
      default: begin
        mac_en = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:   if (clr_cnt_q == ADDR_W'(MAX_LINE - 1)) state_d = ST_MUL;
      ST_MUL:   state_d = ST_OH_GO;
      ST_OH_GO: state_d = ST_OH_WT;
      ST_OH_WT: if (div_rsp.done) state_d = ST_W_GO;
      ST_W_GO:  state_d = ST_W_WT;
      ST_W_WT:  if (div_rsp.done) state_d = ST_H_GO;
      ST_H_GO:  state_d = ST_H_WT;
      ST_H_WT:  if (div_rsp.done) state_d = ST_IDLE;
      ST_IDLE:  if (accept && keep) state_d = ST_MR;
      ST_MR:    state_d = ST_MG;
      ST_MG:    state_d = ST_MB;
      ST_MB:    state_d = ST_L1;
      ST_L1:    state_d = ST_L2;
      ST_L2:    state_d = ST_L3;
      ST_L3:    state_d = ST_Q1;
      ST_Q1:    state_d = ST_Q2;
      ST_Q2:    state_d = ST_Q3;
      ST_Q3:    state_d = ST_FIN;
      ST_FIN:   if (fin_go) state_d = rend ? ST_EXT : ST_IDLE;
      ST_EXT:   state_d = ST_IDLE;
      default:  state_d = ST_CLR;
    endcase
    if (geo_wr) begin
      state_d = ST_CLR;
    end
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_q)
      ST_OH_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mac_q[DIV_N-1:0];
        div_req.divisor  = w_eff;
      end
      ST_W_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N'(w_eff);
        div_req.divisor  = DIM_W'(ow);
      end
      ST_H_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N'(h_eff);
        div_req.divisor  = oh_q;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // error row accesses
  always_comb begin
    mem_req       = '0;
    mem_req.raddr = out_col_q[ADDR_W-1:0];
    mem_req.rbank = bank_q;
    case (state_q)
      ST_CLR: begin
        mem_req.wr0.we   = 1'b1;
        mem_req.wr0.addr = clr_cnt_q;
        mem_req.wr1.we   = 1'b1;
        mem_req.wr1.addr = clr_cnt_q;
      end
      ST_FIN: begin
        if (bank_q) begin
          mem_req.wr1.we   = fin_go;
          mem_req.wr1.addr = out_col_q[ADDR_W-1:0];
          mem_req.wr0.we   = fin_go && !last_row && (out_col_q != '0);
          mem_req.wr0.addr = ADDR_W'(out_col_q - 1'b1);
          mem_req.wr0.data = nxt_data;
        end else begin
          mem_req.wr0.we   = fin_go;
          mem_req.wr0.addr = out_col_q[ADDR_W-1:0];
          mem_req.wr1.we   = fin_go && !last_row && (out_col_q != '0);
          mem_req.wr1.addr = ADDR_W'(out_col_q - 1'b1);
          mem_req.wr1.data = nxt_data;
        end
      end
      ST_EXT: begin
        if (bank_q) begin
          mem_req.wr0.we   = !ext_last_q;
          mem_req.wr0.addr = ADDR_W'(ow - 1'b1);
          mem_req.wr0.data = ext_q;
        end else begin
          mem_req.wr1.we   = !ext_last_q;
          mem_req.wr1.addr = ADDR_W'(ow - 1'b1);
          mem_req.wr1.data = ext_q;
        end
      end
      default: begin
        mem_req.wr0.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_en) begin
      mac_q <= (mac_clr ? '0 : mac_q) + ({{MAC_B_W{1'b0}}, mac_a} * {{MAC_A_W{1'b0}}, mac_b});
    end
    if (accept) begin
      pr_q <= pix_i.red;
      pg_q <= pix_i.green;
      pb_q <= pix_i.blue;
      pa_q <= pix_i.alpha;
    end
    case (state_q)
      ST_MR: terr_q <= mem_rdata;
      ST_MG: cr_q   <= chan;
      ST_MB: cg_q   <= chan;
      ST_L1: cb_q   <= chan;
      ST_Q1: lumx_q <= mac_q[MAC_A_W-1:0];
      ST_Q2: q0_q   <= mac_q[MAC_W-1:20];
      ST_Q3: begin
        dark_q <= dark_c;
        e_q    <= e_c;
      end
      default: begin
        dark_q <= dark_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_w_q     <= OUT_W'(384);
      thr_q       <= 8'd128;
      srcw_q      <= DIM_W'(1);
      srch_q      <= DIM_W'(1);
      clr_cnt_q   <= '0;
      oh_q        <= DIM_W'(1);
      qw_q        <= '0;
      rw_q        <= '0;
      qh_q        <= '0;
      rh_q        <= '0;
      src_col_q   <= '0;
      src_row_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      wc_q        <= '0;
      wr_q        <= '0;
      rem_col_q   <= '0;
      rem_row_q   <= '0;
      carry_q     <= '0;
      pend1_q     <= '0;
      pend2_q     <= '0;
      ext_q       <= '0;
      ext_last_q  <= 1'b0;
      bank_q      <= 1'b0;
      dot_valid_q <= 1'b0;
      ink_q       <= 1'b0;
      rend_q      <= 1'b0;
      iend_q      <= 1'b0;
    end else begin
      if (state_q == ST_CLR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == ST_OH_WT && div_rsp.done) begin
        oh_q <= (div_rsp.quot[DIM_W-1:0] == '0) ? DIM_W'(1) : div_rsp.quot[DIM_W-1:0];
      end
      if (state_q == ST_W_WT && div_rsp.done) begin
        qw_q <= div_rsp.quot[DIM_W-1:0];
        rw_q <= div_rsp.rem[OUT_W-1:0];
      end
      if (state_q == ST_H_WT && div_rsp.done) begin
        qh_q <= div_rsp.quot[DIM_W-1:0];
        rh_q <= div_rsp.rem;
      end

      if (fin_go) begin
        dot_valid_q <= 1'b1;
        ink_q       <= dark_q;
        rend_q      <= rend;
        iend_q      <= rend && last_row;
        if (rend) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + 1'b1;
          wc_q       <= '0;
          rem_col_q  <= '0;
          wr_q       <= wr_q + qh_q + DIM_W'(row_wrap);
          rem_row_q  <= row_wrap ? DIM_W'(row_sum - {1'b0, oh_q}) : row_sum[DIM_W-1:0];
          carry_q    <= '0;
          pend1_q    <= '0;
          pend2_q    <= '0;
          ext_q      <= pend1_n;
          ext_last_q <= last_row;
        end else begin
          out_col_q <= out_col_q + 1'b1;
          wc_q      <= wc_q + qw_q + DIM_W'(col_wrap);
          rem_col_q <= col_wrap ? OUT_W'(col_sum - {1'b0, ow}) : col_sum[OUT_W-1:0];
          carry_q   <= ERR_W'(13'sd7 * e13);
          pend1_q   <= pend1_n;
          pend2_q   <= e13;
        end
      end else if (dot_o.ready) begin
        dot_valid_q <= 1'b0;
      end

      if (state_q == ST_EXT) begin
        bank_q <= !bank_q;
      end

      if (adv) begin
        if (src_col_last) begin
          src_col_q <= '0;
          if (src_row_last) begin
            src_row_q <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
            wc_q      <= '0;
            wr_q      <= '0;
            rem_col_q <= '0;
            rem_row_q <= '0;
            carry_q   <= '0;
            pend1_q   <= '0;
            pend2_q   <= '0;
          end else begin
            src_row_q <= src_row_q + 1'b1;
          end
        end else begin
          src_col_q <= src_col_q + 1'b1;
        end
      end

      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_MAX_WIDTH:     max_w_q <= cfg_data_i[OUT_W-1:0];
          REG_THRESHOLD:     thr_q   <= cfg_data_i[7:0];
          REG_SOURCE_WIDTH:  srcw_q  <= cfg_data_i;
          REG_SOURCE_HEIGHT: srch_q  <= cfg_data_i;
          default:           thr_q   <= thr_q;
        endcase
      end
      if (geo_wr) begin
        clr_cnt_q <= '0;
        src_col_q <= '0;
        src_row_q <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        wc_q      <= '0;
        wr_q      <= '0;
        rem_col_q <= '0;
        rem_row_q <= '0;
        carry_q   <= '0;
        pend1_q   <= '0;
        pend2_q   <= '0;
      end
    end
  end

  assign dot_o.valid     = dot_valid_q;
  assign dot_o.ink       = ink_q;
  assign dot_o.row_end   = rend_q;
  assign dot_o.image_end = iend_q;

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (out_col_q < ow))
    else $error("output column beyond line width");

  a_col_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (rem_col_q < ow))
    else $error("column step remainder out of range");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (out_row_q <= oh_q))
    else $error("output row beyond image height");

  a_fin_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> dot_valid_q)
    else $error("finished dot not presented");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scaled_error_diffusion_dither_core. The bench
// streams RGBA pixels over a run of image geometries and thresholds.
// A built-in dither and downscale predictor works out the expected dot
// beats, and each beat taken from the block is compared field by field.
// ----------------------------------------------------------------------------
module tb import sedd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic ink;
    logic row_end;
    logic image_end;
  } dot_t;

  localparam int IDLE_LIMIT = 20000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [DIM_W-1:0] cfg_data_i;

  sedd_pix_if pix();
  sedd_dot_if dot();

  scaled_error_diffusion_dither_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix.sink),
    .dot_o      (dot.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  pix_t pix_q[$];
  dot_t dots_due[$];
  int   n_errors;
  int   n_pixels;
  int   n_dots;
  int   n_images;
  int   idle_cycles;

  // ---- predictor ----
  int unsigned mdl_max_w, mdl_thr, mdl_src_w, mdl_src_h;
  int          err_this[MAX_LINE+2];
  int          err_next[MAX_LINE+2];
  int unsigned src_col, src_row, out_col, out_row, want_col, want_row;

  function automatic int unsigned src_w_eff();
    return (mdl_src_w == 0) ? 1 : mdl_src_w;
  endfunction

  function automatic int unsigned src_h_eff();
    return (mdl_src_h == 0) ? 1 : mdl_src_h;
  endfunction

  function automatic int unsigned out_w_eff();
    int unsigned m;
    m = (mdl_max_w == 0) ? 1 : mdl_max_w;
    if (m > MAX_LINE) m = MAX_LINE;
    return (src_w_eff() > m) ? m : src_w_eff();
  endfunction

  function automatic int unsigned out_h_eff();
    longint unsigned h;
    h = (longint'(src_h_eff()) * out_w_eff()) / src_w_eff();
    return (h == 0) ? 1 : int'(h);
  endfunction

  function automatic void aim_scaler();
    want_col = int'((longint'(out_col) * src_w_eff()) / out_w_eff());
    want_row = int'((longint'(out_row) * src_h_eff()) / out_h_eff());
  endfunction

  function automatic void new_image();
    foreach (err_this[i]) begin
      err_this[i] = 0;
      err_next[i] = 0;
    end
    src_col = 0;
    src_row = 0;
    out_col = 0;
    out_row = 0;
    aim_scaler();
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [DIM_W-1:0] val);
    case (idx)
      REG_MAX_WIDTH: begin
        mdl_max_w = val[10:0];
        new_image();
      end
      REG_THRESHOLD: mdl_thr = val[7:0];
      REG_SOURCE_WIDTH: begin
        mdl_src_w = val;
        new_image();
      end
      REG_SOURCE_HEIGHT: begin
        mdl_src_h = val;
        new_image();
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned blend_white(int unsigned c, int unsigned a);
    return (c * a + 255 * (255 - a)) / 255;
  endfunction

  function automatic void dither_pixel(pix_t p);
    int unsigned ow, oh, r, g, b, lum, x;
    int          v, e;
    dot_t        d;
    ow = out_w_eff();
    oh = out_h_eff();
    if (out_row < oh && src_row == want_row && src_col == want_col) begin
      r   = blend_white(p.red, p.alpha);
      g   = blend_white(p.green, p.alpha);
      b   = blend_white(p.blue, p.alpha);
      lum = (299 * r + 587 * g + 114 * b) / 1000;
      x   = out_col;
      v   = int'(lum) + err_this[x+1] / 16;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      d.ink = (v < int'(mdl_thr));
      e = d.ink ? v : v - 255;
      err_this[x+2] += e * 7;
      err_next[x]   += e * 3;
      err_next[x+1] += e * 5;
      err_next[x+2] += e;
      d.row_end   = (x + 1) >= ow;
      d.image_end = d.row_end && (out_row + 1) >= oh;
      dots_due.push_back(d);
      if (d.row_end) begin
        out_col = 0;
        out_row++;
        err_this = err_next;
        foreach (err_next[i]) err_next[i] = 0;
      end else begin
        out_col++;
      end
      aim_scaler();
    end
    if (src_col + 1 >= src_w_eff()) begin
      src_col = 0;
      if (src_row + 1 >= src_h_eff()) new_image();
      else src_row++;
    end else begin
      src_col++;
    end
  endfunction

  // ---- clock and reset ----
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---- pixel driver ----
  int unsigned pix_gap;
  logic        pix_burst;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.red   <= '0;
      pix.green <= '0;
      pix.blue  <= '0;
      pix.alpha <= '0;
      pix_gap   = 0;
      pix_burst = 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        dither_pixel(pix_q.pop_front());
        n_pixels++;
        if ($urandom_range(0, 63) == 0) pix_burst = ~pix_burst;
        pix_gap = pix_burst ? 0 : $urandom_range(0, 8);
      end
      if (!pix.valid || pix.ready) begin
        if (pix_gap > 0) begin
          pix_gap--;
          pix.valid <= 1'b0;
        end else if (pix_q.size() > 0) begin
          pix.valid <= 1'b1;
          pix.red   <= pix_q[0].red;
          pix.green <= pix_q[0].green;
          pix.blue  <= pix_q[0].blue;
          pix.alpha <= pix_q[0].alpha;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // ---- dot monitor ----
  int unsigned dot_hold;
  logic        dot_burst;
  logic        long_hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    dot_t got, want;
    if (!rst_ni) begin
      dot.ready      <= 1'b0;
      dot_hold       = 0;
      dot_burst      = 1'b0;
      long_hold_done = 1'b0;
    end else begin
      if (dot.valid && dot.ready) begin
        got = '{dot.ink, dot.row_end, dot.image_end};
        n_dots++;
        if (got.image_end) n_images++;
        if (dots_due.size() == 0) begin
          $display("%0t: unexpected dot beat %b", $time, got);
          n_errors++;
        end else begin
          want = dots_due.pop_front();
          if (got.ink !== want.ink) begin
            $display("%0t: ink expected %b actual %b", $time, want.ink, got.ink);
            n_errors++;
          end
          if (got.row_end !== want.row_end) begin
            $display("%0t: row_end expected %b actual %b", $time, want.row_end,
                     got.row_end);
            n_errors++;
          end
          if (got.image_end !== want.image_end) begin
            $display("%0t: image_end expected %b actual %b", $time, want.image_end,
                     got.image_end);
            n_errors++;
          end
        end
        if ($urandom_range(0, 63) == 0) dot_burst = ~dot_burst;
        dot_hold = dot_burst ? 0 : $urandom_range(0, 8);
        // one long back-pressure stretch while pixels keep coming
        if (!long_hold_done && n_dots == 300) begin
          dot_hold       = 400;
          long_hold_done = 1'b1;
        end
        dot.ready <= (dot_hold == 0);
      end else if (dot_hold > 0) begin
        dot_hold--;
        dot.ready <= (dot_hold == 0);
      end else begin
        dot.ready <= 1'b1;
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    if (!rst_ni || (pix.valid && pix.ready) || (dot.valid && dot.ready) || cfg_we_i)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---- stimulus ----
  task automatic write_reg(reg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[DIM_W-1:0];
    apply_reg(idx, val[DIM_W-1:0]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pix_q.size() != 0 || pix.valid || dots_due.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic pix_t rand_pixel();
    pix_t p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0: p.alpha = 8'd255;
      1: p.alpha = 8'd0;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixels(int n);
    repeat (n) pix_q.push_back(rand_pixel());
  endtask

  initial begin
    int unsigned sw, sh, mw, k;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    n_errors   = 0;
    n_pixels   = 0;
    n_dots     = 0;
    n_images   = 0;
    idle_cycles = 0;
    mdl_max_w = 384;
    mdl_thr   = 128;
    mdl_src_w = 1;
    mdl_src_h = 1;
    new_image();
    @(posedge rst_ni);

    // directed: 1x1 images, extreme pixels and thresholds
    pix_q.push_back('{8'd0, 8'd0, 8'd0, 8'd255});
    pix_q.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    pix_q.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
    pix_q.push_back('{8'd128, 8'd128, 8'd128, 8'd255});
    pix_q.push_back('{8'd127, 8'd127, 8'd127, 8'd255});
    pix_q.push_back('{8'd255, 8'd0, 8'd0, 8'd128});
    drain();
    write_reg(REG_THRESHOLD, 0);
    pix_q.push_back('{8'd0, 8'd0, 8'd0, 8'd255});
    drain();
    write_reg(REG_THRESHOLD, 255);
    pix_q.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    pix_q.push_back('{8'd254, 8'd255, 8'd255, 8'd255});
    drain();
    // zero geometry, oversized max width, largest source dims
    write_reg(REG_THRESHOLD, 128);
    write_reg(REG_MAX_WIDTH, 0);
    write_reg(REG_SOURCE_WIDTH, 0);
    write_reg(REG_SOURCE_HEIGHT, 0);
    send_pixels(3);
    drain();
    write_reg(REG_MAX_WIDTH, 2047);
    write_reg(REG_SOURCE_WIDTH, 65535);
    write_reg(REG_SOURCE_HEIGHT, 65535);
    send_pixels(5);
    drain();
    write_reg(REG_MAX_WIDTH, 1024);
    write_reg(REG_SOURCE_WIDTH, 1040);
    write_reg(REG_SOURCE_HEIGHT, 1);
    send_pixels(1040 + 3);
    drain();

    // random images, mostly small
    while (n_pixels < 2000) begin
      if ($urandom_range(0, 3) == 0) write_reg(REG_THRESHOLD, $urandom_range(0, 255));
      sw = $urandom_range(1, 24);
      sh = $urandom_range(1, 12);
      mw = $urandom_range(1, sw + 4);
      if ($urandom_range(0, 9) == 0) mw = 0;
      if ($urandom_range(0, 9) == 0) sw = 0;
      if ($urandom_range(0, 9) == 0) sh = 0;
      write_reg(REG_MAX_WIDTH, mw);
      write_reg(REG_SOURCE_WIDTH, sw);
      write_reg(REG_SOURCE_HEIGHT, sh);
      k = (sw == 0 ? 1 : sw) * (sh == 0 ? 1 : sh);
      send_pixels(k * $urandom_range(1, 2) + $urandom_range(0, 6));
      drain();
    end

    $display("covered %0d pixels, %0d dots, %0d finished images", n_pixels, n_dots,
             n_images);
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
src/sedd_pkg.sv
src/sedd_if.sv
src/sedd_div.sv
src/sedd_err_mem.sv
src/scaled_error_diffusion_dither_core.sv
test/tb.sv
